/* rtl/core/binomial_valuation_histogram_unit_defines.svh */
// assertion macros used by the top-level rtl file
`ifndef BINOMIAL_VALUATION_HISTOGRAM_UNIT_DEFINES_SVH
`define BINOMIAL_VALUATION_HISTOGRAM_UNIT_DEFINES_SVH

// expression that must hold at every edge out of reset
`define BVH_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent that must hold in the same cycle as the antecedent
`define BVH_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/bvh_pkg.sv */
`default_nettype none

package bvh_pkg;

	localparam int DIGIT_W    = 8;
	localparam int K_W        = 6;
	localparam int CNT_W      = 64;
	localparam int HIST_DEPTH = 65;
	localparam int ADDR_W     = 7;
	localparam int OUT_DATA_W = 72;

	localparam logic [K_W-1:0] MAX_K = 6'd63;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SWEEP,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// one read issued into the update pipeline
	typedef struct packed {
		logic           valid;
		logic [K_W-1:0] k;
		logic           is_top;     // k equals the current digit index
		logic           step_zero;  // first digit of the item
	} upd_tag_t;

	typedef struct packed {
		logic [K_W-1:0]   valuation;
		logic [CNT_W-1:0] count;
		logic             last;
	} result_t;

endpackage

`default_nettype wire

/* rtl/core/bvh_ram.sv */
`default_nettype none

module bvh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 65
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/core/bvh_digit_div.sv */
`default_nettype none

module bvh_digit_div
	import bvh_pkg::*;
#(
	parameter int VALUE_BITS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  load,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire logic [DIGIT_W-1:0]    base,
	output logic                       busy,
	output logic      [DIGIT_W-1:0]    digit,
	output logic                       quot_zero
);

	localparam int DIV_STEPS = (VALUE_BITS + 7) / 8;
	localparam int DIV_W     = DIV_STEPS * 8;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);

	logic [DIV_W-1:0]   quot_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [STEP_W-1:0]  step_q;
	logic [DIV_W-1:0]   quot_d;
	logic [DIGIT_W-1:0] rem_d;
	logic [7:0]         qbyte;

	// eight restoring steps, most significant bit first
	always_comb begin
		logic [DIGIT_W:0] rem9;
		rem_d = rem_q;
		qbyte = '0;
		for (int b = 0; b < 8; b++) begin
			rem9 = {rem_d, quot_q[DIV_W-1-b]};
			if (rem9 >= {1'b0, base}) begin
				rem9 = rem9 - {1'b0, base};
				qbyte[7-b] = 1'b1;
			end
			rem_d = rem9[DIGIT_W-1:0];
		end
		quot_d = (quot_q << 8) | DIV_W'(qbyte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= STEP_W'(DIV_STEPS);
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			if (load) begin
				quot_q <= DIV_W'(value);
			end
		end else if (step_q != '0) begin
			rem_q  <= rem_d;
			quot_q <= quot_d;
		end
	end

	assign busy      = (step_q != '0);
	assign digit     = rem_q;
	assign quot_zero = (quot_q == '0);

endmodule

`default_nettype wire

/* rtl/core/bvh_update.sv */
`default_nettype none

module bvh_update
	import bvh_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire upd_tag_t            tag,
	input  wire logic [DIGIT_W-1:0]  digit,
	input  wire logic [DIGIT_W-1:0]  base,
	input  wire logic [CNT_W-1:0]    nb_rdata,
	input  wire logic [CNT_W-1:0]    bw_rdata,
	output logic                     busy,
	output logic                     nb_we,
	output logic      [ADDR_W-1:0]   nb_waddr,
	output logic      [CNT_W-1:0]    nb_wdata,
	output logic                     bw_we,
	output logic      [ADDR_W-1:0]   bw_waddr,
	output logic      [CNT_W-1:0]    bw_wdata
);

	upd_tag_t         tag_s1;
	logic             valid_s2, valid_s3;
	logic [K_W-1:0]   k_s2, k_s3;
	logic [CNT_W-1:0] c0_s2, c0_s3;
	logic [CNT_W-1:0] sum_s2;
	logic [CNT_W-1:0] pnb_s3, pbw_s3;
	logic [CNT_W-1:0] c0, c1;

	// entry at the current digit index was never written this item
	always_comb begin
		if (tag_s1.is_top) begin
			c0 = {{(CNT_W-1){1'b0}}, tag_s1.step_zero};
		end else begin
			c0 = nb_rdata;
		end
		c1 = (tag_s1.k == '0) ? '0 : bw_rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1   <= '0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			tag_s1   <= tag;
			valid_s2 <= tag_s1.valid;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		k_s2   <= tag_s1.k;
		c0_s2  <= c0;
		sum_s2 <= c0 + c1;
		k_s3   <= k_s2;
		c0_s3  <= c0_s2;
		pnb_s3 <= sum_s2 * CNT_W'(digit);
		pbw_s3 <= sum_s2 * CNT_W'(base - digit);
	end

	// nb' = c0 + d*(c0+c1), bw'[k+1] = (p-d)*(c0+c1) - c0
	assign nb_we    = valid_s3;
	assign nb_waddr = {1'b0, k_s3};
	assign nb_wdata = c0_s3 + pnb_s3;
	assign bw_we    = valid_s3;
	assign bw_waddr = ADDR_W'(k_s3) + 1'b1;
	assign bw_wdata = pbw_s3 - c0_s3;

	assign busy = tag_s1.valid | valid_s2 | valid_s3;

endmodule

`default_nettype wire

/* rtl/core/binomial_valuation_histogram_unit.sv */
// Binomial valuation histogram: for each input transfer (value N, base p) the unit counts,
// for every k, how many t in 0..N give C(N,t) exactly k borrows in base p, and sends one
// result transfer per k = 0..r-1 (r = number of base-p digits of N, N = 0 counting as one
// digit), with tlast on the final one. Counts wrap modulo 2^64; a base of 0 or 1 acts as 2.
// An accepted transfer starts a division of N by p, eight quotient bits per cycle. Digit i
// then picks up its digit, sweeps the two count memories from index i down to 0 and drains
// the update pipeline; the division for the next digit runs meanwhile and, with VALUE_BITS
// = 64, is hidden once i reaches 3. The r result reads then go out as the output queue has
// room, and a new read may issue while the previous one's data is still in flight. Each count
// memory has a single read port. No clearing pass is needed: the no-borrow entry at the
// current digit index is substituted rather than read, and entries beyond it are not read.
// One item is in work at a time; results drain through a 2-entry queue.
`default_nettype none

module binomial_valuation_histogram_unit
	import bvh_pkg::*;
#(
	parameter int VALUE_BITS = 64
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      s_axis_tvalid,
	output logic                                           s_axis_tready,
	// value [VALUE_BITS-1:0], base [VALUE_BITS+7:VALUE_BITS], zero fill
	input  wire logic [((VALUE_BITS + 8 + 7) / 8) * 8-1:0] s_axis_tdata,
	output logic                                           m_axis_tvalid,
	input  wire logic                                      m_axis_tready,
	// valuation [5:0], count [69:6], zero fill [71:70]
	output logic      [OUT_DATA_W-1:0]                     m_axis_tdata,
	output logic                                           m_axis_tlast
);

	`include "binomial_valuation_histogram_unit_defines.svh"

	// control state
	state_t             state_q, state_d;
	logic [K_W-1:0]     step_idx_q, step_idx_d;   // digit index i
	logic [K_W-1:0]     k_q, k_d;                 // sweep position, descending
	logic [K_W-1:0]     e_q, e_d;                 // emit position, ascending
	logic [DIGIT_W-1:0] digit_q, digit_d;
	logic [DIGIT_W-1:0] base_q, base_d;
	logic               quot_zero_q, quot_zero_d;

	// divider
	logic               div_start, div_load, div_busy, div_quot_zero;
	logic [DIGIT_W-1:0] div_digit;
	logic [DIGIT_W-1:0] in_base;

	// memories and update pipeline
	upd_tag_t           tag;
	logic               upd_busy;
	logic               nb_we, bw_we;
	logic [ADDR_W-1:0]  nb_waddr, bw_waddr, nb_raddr, bw_raddr;
	logic [CNT_W-1:0]   nb_wdata, bw_wdata, nb_rdata, bw_rdata;

	// result read path and output queue
	logic               rd_issue, credit;
	logic               rd_valid_q, rd_last_q;
	logic [K_W-1:0]     rd_k_q;
	result_t            fifo_q [2];
	logic               wr_ptr_q, rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               push, pop;
	result_t            head;

	assign in_base = s_axis_tdata[VALUE_BITS +: DIGIT_W];

	bvh_digit_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.load     (div_load),
		.value    (s_axis_tdata[VALUE_BITS-1:0]),
		.base     (base_q),
		.busy     (div_busy),
		.digit    (div_digit),
		.quot_zero(div_quot_zero)
	);

	// counts with no borrow pending; also the result source
	bvh_ram #(
		.WIDTH(CNT_W),
		.DEPTH(HIST_DEPTH)
	) u_nb_ram (
		.clk  (clk),
		.we   (nb_we),
		.waddr(nb_waddr),
		.wdata(nb_wdata),
		.raddr(nb_raddr),
		.rdata(nb_rdata)
	);

	// counts with a borrow pending into the next digit
	bvh_ram #(
		.WIDTH(CNT_W),
		.DEPTH(HIST_DEPTH)
	) u_bw_ram (
		.clk  (clk),
		.we   (bw_we),
		.waddr(bw_waddr),
		.wdata(bw_wdata),
		.raddr(bw_raddr),
		.rdata(bw_rdata)
	);

	bvh_update u_update (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag     (tag),
		.digit   (digit_q),
		.base    (base_q),
		.nb_rdata(nb_rdata),
		.bw_rdata(bw_rdata),
		.busy    (upd_busy),
		.nb_we   (nb_we),
		.nb_waddr(nb_waddr),
		.nb_wdata(nb_wdata),
		.bw_we   (bw_we),
		.bw_waddr(bw_waddr),
		.bw_wdata(bw_wdata)
	);

	// sweep reads run from the top index down, so each write but the borrow write above
	// the top index lands on an entry already read in this sweep
	assign nb_raddr = (state_q == ST_EMIT) ? {1'b0, e_q} : {1'b0, k_q};
	assign bw_raddr = {1'b0, k_q};

	// queue slots plus the read in flight never exceed two
	assign credit = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && !rd_valid_q);

	always_comb begin
		state_d     = state_q;
		step_idx_d  = step_idx_q;
		k_d         = k_q;
		e_d         = e_q;
		digit_d     = digit_q;
		base_d      = base_q;
		quot_zero_d = quot_zero_q;
		div_start   = 1'b0;
		div_load    = 1'b0;
		tag         = '0;
		rd_issue    = 1'b0;
		s_axis_tready = 1'b0;

		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					div_start  = 1'b1;
					div_load   = 1'b1;
					step_idx_d = '0;
					// base below two acts as two
					base_d     = (in_base < DIGIT_W'(2)) ? DIGIT_W'(2) : in_base;
					state_d    = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!div_busy) begin
					digit_d     = div_digit;
					quot_zero_d = div_quot_zero;
					k_d         = step_idx_q;
					// next digit divides while this one sweeps
					div_start   = !div_quot_zero;
					state_d     = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				tag.valid     = 1'b1;
				tag.k         = k_q;
				tag.is_top    = (k_q == step_idx_q);
				tag.step_zero = (step_idx_q == '0);
				if (k_q == '0) begin
					state_d = ST_DRAIN;
				end else begin
					k_d = k_q - 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!upd_busy) begin
					if (quot_zero_q || (step_idx_q == MAX_K)) begin
						e_d     = '0;
						state_d = ST_EMIT;
					end else begin
						step_idx_d = step_idx_q + 1'b1;
						state_d    = ST_DIV;
					end
				end
			end
			ST_EMIT: begin
				if (credit) begin
					rd_issue = 1'b1;
					if (e_q == step_idx_q) begin
						state_d = ST_IDLE;
					end else begin
						e_d = e_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_valid_q <= rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		step_idx_q  <= step_idx_d;
		k_q         <= k_d;
		e_q         <= e_d;
		digit_q     <= digit_d;
		base_q      <= base_d;
		quot_zero_q <= quot_zero_d;
		rd_last_q   <= rd_issue && (e_q == step_idx_q);
		rd_k_q      <= e_q;
	end

	// output queue: result data arrives in the cycle after its read is issued
	assign push = rd_valid_q;
	assign pop  = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{valuation: rd_k_q, count: nb_rdata, last: rd_last_q};
		end
	end

	assign head          = fifo_q[rd_ptr_q];
	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata  = {2'b00, head.count, head.valuation};
	assign m_axis_tlast  = head.last;

	`BVH_ASSERT_ALWAYS(a_queue_bound, ({1'b0, cnt_q} + {2'b00, rd_valid_q}) <= 3'd2,
		"output queue overrun")
	`BVH_ASSERT_IMPL(a_sweep_in_range, state_q == ST_SWEEP, k_q <= step_idx_q,
		"sweep position beyond digit index")
	`BVH_ASSERT_IMPL(a_emit_quiet, state_q == ST_EMIT, !upd_busy && !div_busy,
		"update or divide active during result reads")
	`BVH_ASSERT_IMPL(a_push_only_after_read, push, $past(state_q) == ST_EMIT,
		"result queued without a preceding read")

endmodule

`default_nettype wire
